// ===== design/dnsl_pkg.sv =====
// package with shared types and constants of the dns server list table
`timescale 1ns / 1ps
`default_nettype none
package dnsl_pkg;

  localparam int unsigned SERVER_SLOTS = 4;
  localparam int unsigned MAX_OPTION_ADDRESSES = 8;
  localparam int unsigned SLOT_W = $clog2(SERVER_SLOTS);
  localparam int unsigned PEND_W = $clog2(MAX_OPTION_ADDRESSES);
  localparam int unsigned CNT_W = $clog2(MAX_OPTION_ADDRESSES + 1);
  localparam int unsigned SCNT_W = $clog2(SERVER_SLOTS + 1);
  localparam logic [31:0] LIFE_INF = 32'hFFFF_FFFF;
  localparam logic [7:0] MCAST_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    CMD_OPTION = 3'd0,
    CMD_GET    = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ERROR   = 2'd1,
    ST_NONE    = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  // job handed from the front to the back
  typedef struct packed {
    logic [2:0]  cmd;
    logic        bad;
    logic [CNT_W-1:0] cnt;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [31:0] life;
    logic [31:0] now_ms;
    logic [7:0]  index;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_START,
    BK_APPLY,
    BK_EVICT,
    BK_INSERT,
    BK_DONE
  } back_state_e;

endpackage
`default_nettype wire

// ===== design/dns_server_list_table.sv =====
// top level of the dns server list table
`timescale 1ns / 1ps
`default_nettype none
// Keeps up to four IPv6 DNS servers in a packed list with expiry times. The front
// buffers option addresses and queues jobs in a two-entry queue; the back carries
// out get, find, remove and tick in its idle state and puts the result in the output
// register when it is free. A closing option item steps each buffered address through
// the back sequencer (match, optional eviction, insert shift), then a done state; the
// front takes no new item until the option is applied, or a bad one taken by the back.
module dns_server_list_table
  import dnsl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [63:0] addr_high_i,
  input  wire logic [63:0] addr_low_i,
  input  wire logic [31:0] lifetime_s_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [7:0]  index_i,
  input  wire logic        last_of_option_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [1:0]       status_o,
  output logic [2:0]       entry_index_o,
  output logic [63:0]      entry_addr_high_o,
  output logic [63:0]      entry_addr_low_o,
  output logic [63:0]      expire_time_o,
  output logic             never_expires_o,
  output logic [2:0]       server_count_o,
  output logic [3:0]       added_count_o,
  output logic [3:0]       updated_count_o,
  output logic [3:0]       deleted_count_o,
  output logic [3:0]       evicted_count_o
);

  logic job_valid, job_ready, opt_done;
  job_t job;
  logic [PEND_W-1:0] pend_idx;
  logic [63:0] pend_high, pend_low;

  dnsl_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .command_i, .addr_high_i, .addr_low_i,
    .lifetime_s_i, .now_ms_i, .index_i, .last_of_option_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job),
    .opt_done_i(opt_done),
    .pend_idx_i(pend_idx), .pend_high_o(pend_high), .pend_low_o(pend_low)
  );

  dnsl_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .opt_done_o(opt_done),
    .pend_idx_o(pend_idx), .pend_high_i(pend_high), .pend_low_i(pend_low),
    .valid_o, .ready_i, .status_o, .entry_index_o, .entry_addr_high_o,
    .entry_addr_low_o, .expire_time_o, .never_expires_o, .server_count_o,
    .added_count_o, .updated_count_o, .deleted_count_o, .evicted_count_o
  );

endmodule
`default_nettype wire

// ===== design/dnsl_front.sv =====
// front: buffers option addresses, checks them, queues jobs for the back
`timescale 1ns / 1ps
`default_nettype none
module dnsl_front
  import dnsl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [63:0] addr_high_i,
  input  wire logic [63:0] addr_low_i,
  input  wire logic [31:0] lifetime_s_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [7:0]  index_i,
  input  wire logic        last_of_option_i,
  output logic             job_valid_o,
  input  wire logic        job_ready_i,
  output job_t             job_o,
  input  wire logic        opt_done_i,
  input  wire logic [PEND_W-1:0] pend_idx_i,
  output logic [63:0]      pend_high_o,
  output logic [63:0]      pend_low_o
);

  logic [63:0] pend_high_q [MAX_OPTION_ADDRESSES];
  logic [63:0] pend_low_q  [MAX_OPTION_ADDRESSES];
  logic [CNT_W-1:0] pcount_q, pcount_d;
  logic over_q, over_d, bad_q, bad_d;
  // two entry job queue
  job_t fifo_q [2];
  logic [1:0] fcnt_q;
  logic rd_q, wr_q;
  logic busy_q;  // an option job owns the buffer until the back finishes it

  logic acc, push, pop, room, is_opt, bad_addr, full_buf;
  job_t nj;

  assign is_opt = (command_i == CMD_OPTION);
  assign full_buf = (pcount_q == CNT_W'(MAX_OPTION_ADDRESSES));
  assign bad_addr = (addr_high_i[63:56] == MCAST_BYTE) ||
                    (addr_high_i == 64'd0 && addr_low_i == 64'd0);
  assign room = (fcnt_q != 2'd2);
  assign ready_o = room && !busy_q;
  assign acc = valid_i && ready_o;
  assign pop = job_valid_o && job_ready_i;
  assign job_valid_o = (fcnt_q != 2'd0);
  assign job_o = fifo_q[rd_q];

  always_comb begin
    pcount_d = pcount_q;
    over_d = over_q;
    bad_d = bad_q;
    push = 1'b0;
    if (acc) begin
      if (is_opt) begin
        if (!full_buf) begin
          pcount_d = pcount_q + CNT_W'(1);
          if (bad_addr) bad_d = 1'b1;
        end else begin
          over_d = 1'b1;
        end
        if (last_of_option_i) begin
          push = 1'b1;
          pcount_d = '0;
          over_d = 1'b0;
          bad_d = 1'b0;
        end
      end else begin
        push = 1'b1;
      end
    end
    nj.cmd = command_i;
    nj.bad = full_buf | over_q | bad_q | (!full_buf && bad_addr);
    nj.cnt = full_buf ? pcount_q : pcount_q + CNT_W'(1);
    nj.addr_high = addr_high_i;
    nj.addr_low = addr_low_i;
    nj.life = lifetime_s_i;
    nj.now_ms = now_ms_i;
    nj.index = index_i;
  end

  always_ff @(posedge clk_i) begin
    if (acc && is_opt && !full_buf) begin
      pend_high_q[pcount_q[PEND_W-1:0]] <= addr_high_i;
      pend_low_q[pcount_q[PEND_W-1:0]] <= addr_low_i;
    end
    pend_high_o <= pend_high_q[pend_idx_i];
    pend_low_o <= pend_low_q[pend_idx_i];
    if (push) fifo_q[wr_q] <= nj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= '0;
      over_q <= 1'b0;
      bad_q <= 1'b0;
      fcnt_q <= 2'd0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      busy_q <= 1'b0;
    end else begin
      pcount_q <= pcount_d;
      over_q <= over_d;
      bad_q <= bad_d;
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      fcnt_q <= fcnt_q + {1'b0, push} - {1'b0, pop};
      if (push && is_opt) busy_q <= 1'b1;
      else if (opt_done_i || (pop && job_o.cmd == CMD_OPTION && job_o.bad)) busy_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== design/dnsl_back.sv =====
// back: keeps the server list and carries out queued jobs
`timescale 1ns / 1ps
`default_nettype none
module dnsl_back
  import dnsl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  output logic             job_ready_o,
  input  wire job_t        job_i,
  output logic             opt_done_o,
  output logic [PEND_W-1:0] pend_idx_o,
  input  wire logic [63:0] pend_high_i,
  input  wire logic [63:0] pend_low_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [1:0]       status_o,
  output logic [2:0]       entry_index_o,
  output logic [63:0]      entry_addr_high_o,
  output logic [63:0]      entry_addr_low_o,
  output logic [63:0]      expire_time_o,
  output logic             never_expires_o,
  output logic [2:0]       server_count_o,
  output logic [3:0]       added_count_o,
  output logic [3:0]       updated_count_o,
  output logic [3:0]       deleted_count_o,
  output logic [3:0]       evicted_count_o
);

  localparam logic [SLOT_W:0] NONE = (SLOT_W+1)'(SERVER_SLOTS);

  logic [63:0] lh_q [SERVER_SLOTS], lh_d [SERVER_SLOTS];
  logic [63:0] ll_q [SERVER_SLOTS], ll_d [SERVER_SLOTS];
  logic [63:0] le_q [SERVER_SLOTS], le_d [SERVER_SLOTS];
  logic        li_q [SERVER_SLOTS], li_d [SERVER_SLOTS];
  logic [SCNT_W-1:0] n_q, n_d;
  logic [31:0] clast_q, clast_d, chigh_q, chigh_d;
  back_state_e st_q, st_d;
  job_t job_q, job_d;
  logic [CNT_W-1:0] pi_q, pi_d;
  logic [SCNT_W-1:0] cur_q, cur_d;
  logic [63:0] now_q, now_d, lifems_q, lifems_d;
  logic [3:0] na_q, na_d, nu_q, nu_d, nd_q, nd_d, ne_q, ne_d;
  logic [SLOT_W:0] vict_q, vict_d;
  logic ovalid_q, ovalid_d;
  logic [1:0] ost_q, ost_d;
  logic [2:0] oidx_q, oidx_d;
  logic [63:0] oh_q, oh_d, ol_q, ol_d, oe_q, oe_d;
  logic oi_q, oi_d;
  logic [2:0] on_q, on_d;
  logic [3:0] oa_q, oa_d, ou_q, ou_d, od_q, od_d, oev_q, oev_d;

  // list match on the job address or the pending address
  logic [63:0] mh, ml;
  logic [SLOT_W:0] hit, due, soon;
  logic [63:0] now_c;
  logic [31:0] chigh_c;
  logic [63:0] left_b, left_i;
  logic binf;

  assign pend_idx_o = pi_q[PEND_W-1:0];
  assign job_ready_o = (st_q == BK_IDLE) && !(ovalid_q && !ready_i);
  assign opt_done_o = (st_q == BK_DONE) && (!ovalid_q || ready_i);

  always_comb begin
    mh = (st_q == BK_IDLE) ? job_i.addr_high : pend_high_i;
    ml = (st_q == BK_IDLE) ? job_i.addr_low : pend_low_i;
    hit = NONE;
    for (int i = SERVER_SLOTS - 1; i >= 0; i--)
      if (SCNT_W'(i) < n_q && lh_q[i] == mh && ll_q[i] == ml) hit = (SLOT_W+1)'(i);
    chigh_c = (job_i.now_ms < clast_q) ? chigh_q + 32'd1 : chigh_q;
    now_c = {chigh_c, job_i.now_ms};
    due = NONE;
    for (int i = SERVER_SLOTS - 1; i >= 0; i--)
      if (SCNT_W'(i) < n_q && !li_q[i] && now_c > le_q[i]) due = (SLOT_W+1)'(i);
    // soonest expiry scan over the used slots
    soon = NONE;
    left_b = '0;
    binf = 1'b1;
    for (int i = 0; i < SERVER_SLOTS; i++) begin
      left_i = (now_q > le_q[i]) ? 64'd0 : le_q[i] - now_q;
      if (SCNT_W'(i) < n_q) begin
        if (soon == NONE || (!li_q[i] && (binf || left_i < left_b))) begin
          soon = (SLOT_W+1)'(i);
          left_b = left_i;
          binf = li_q[i];
        end
      end
    end
  end

  always_comb begin
    st_d = st_q;
    job_d = job_q;
    pi_d = pi_q;
    cur_d = cur_q;
    now_d = now_q;
    lifems_d = lifems_q;
    na_d = na_q; nu_d = nu_q; nd_d = nd_q; ne_d = ne_q;
    vict_d = vict_q;
    n_d = n_q;
    clast_d = clast_q;
    chigh_d = chigh_q;
    for (int i = 0; i < SERVER_SLOTS; i++) begin
      lh_d[i] = lh_q[i]; ll_d[i] = ll_q[i]; le_d[i] = le_q[i]; li_d[i] = li_q[i];
    end
    ovalid_d = ovalid_q && !ready_i;
    ost_d = ost_q; oidx_d = oidx_q; oh_d = oh_q; ol_d = ol_q; oe_d = oe_q;
    oi_d = oi_q; on_d = on_q; oa_d = oa_q; ou_d = ou_q; od_d = od_q; oev_d = oev_q;

    case (st_q)
      BK_IDLE: begin
        if (job_valid_i && job_ready_o) begin
          ovalid_d = 1'b1;
          ost_d = ST_ERROR;
          oidx_d = 3'(NONE);
          oh_d = '0; ol_d = '0; oe_d = '0; oi_d = 1'b0;
          on_d = 3'(n_q);
          oa_d = '0; ou_d = '0; od_d = '0; oev_d = '0;
          case (job_i.cmd)
            CMD_OPTION: begin
              if (job_i.bad) begin
                ost_d = ST_IGNORED;
              end else begin
                ovalid_d = 1'b0;
                job_d = job_i;
                clast_d = job_i.now_ms;
                chigh_d = chigh_c;
                now_d = now_c;
                lifems_d = 64'(job_i.life) * 64'd1000;
                pi_d = '0;
                cur_d = '0;
                na_d = '0; nu_d = '0; nd_d = '0; ne_d = '0;
                st_d = BK_START;
              end
            end
            CMD_GET: begin
              if (job_i.index < 8'(n_q)) begin
                ost_d = ST_OK;
                oidx_d = 3'(job_i.index);
                oh_d = lh_q[job_i.index[SLOT_W-1:0]];
                ol_d = ll_q[job_i.index[SLOT_W-1:0]];
                oe_d = le_q[job_i.index[SLOT_W-1:0]];
                oi_d = li_q[job_i.index[SLOT_W-1:0]];
              end
            end
            CMD_FIND, CMD_REMOVE: begin
              if (hit != NONE) begin
                ost_d = ST_OK;
                oidx_d = 3'(hit);
                oh_d = lh_q[hit[SLOT_W-1:0]];
                ol_d = ll_q[hit[SLOT_W-1:0]];
                oe_d = le_q[hit[SLOT_W-1:0]];
                oi_d = li_q[hit[SLOT_W-1:0]];
                if (job_i.cmd == CMD_REMOVE) begin
                  for (int i = 0; i < SERVER_SLOTS - 1; i++)
                    if ((SLOT_W+1)'(i) >= hit) begin
                      lh_d[i] = lh_q[i+1]; ll_d[i] = ll_q[i+1];
                      le_d[i] = le_q[i+1]; li_d[i] = li_q[i+1];
                    end
                  n_d = n_q - SCNT_W'(1);
                  on_d = 3'(n_d);
                  od_d = 4'd1;
                end
              end
            end
            CMD_TICK: begin
              clast_d = job_i.now_ms;
              chigh_d = chigh_c;
              if (due != NONE) begin
                ost_d = ST_OK;
                oidx_d = 3'(due);
                oh_d = lh_q[due[SLOT_W-1:0]];
                ol_d = ll_q[due[SLOT_W-1:0]];
                oe_d = le_q[due[SLOT_W-1:0]];
                oi_d = li_q[due[SLOT_W-1:0]];
                for (int i = 0; i < SERVER_SLOTS - 1; i++)
                  if ((SLOT_W+1)'(i) >= due) begin
                    lh_d[i] = lh_q[i+1]; ll_d[i] = ll_q[i+1];
                    le_d[i] = le_q[i+1]; li_d[i] = li_q[i+1];
                  end
                n_d = n_q - SCNT_W'(1);
                on_d = 3'(n_d);
              end else begin
                ost_d = ST_NONE;
              end
            end
            default: ;
          endcase
        end
      end
      BK_START: begin
        // pending read address settles here
        st_d = (pi_q < job_q.cnt) ? BK_APPLY : BK_DONE;
      end
      BK_APPLY: begin
        if (hit != NONE) begin
          if (job_q.life == 32'd0) begin
            for (int i = 0; i < SERVER_SLOTS - 1; i++)
              if ((SLOT_W+1)'(i) >= hit) begin
                lh_d[i] = lh_q[i+1]; ll_d[i] = ll_q[i+1];
                le_d[i] = le_q[i+1]; li_d[i] = li_q[i+1];
              end
            n_d = n_q - SCNT_W'(1);
            nd_d = nd_q + 4'd1;
            if (cur_q > SCNT_W'(hit)) cur_d = cur_q - SCNT_W'(1);
          end else begin
            li_d[hit[SLOT_W-1:0]] = (job_q.life == LIFE_INF);
            le_d[hit[SLOT_W-1:0]] = (job_q.life == LIFE_INF) ? 64'd0 :
                                    now_q + lifems_q;
            nu_d = nu_q + 4'd1;
          end
          pi_d = pi_q + CNT_W'(1);
          st_d = BK_START;
        end else if (job_q.life == 32'd0) begin
          pi_d = pi_q + CNT_W'(1);
          st_d = BK_START;
        end else if (n_q == SCNT_W'(SERVER_SLOTS)) begin
          vict_d = soon;
          st_d = BK_EVICT;
        end else begin
          st_d = BK_INSERT;
        end
      end
      BK_EVICT: begin
        for (int i = 0; i < SERVER_SLOTS - 1; i++)
          if ((SLOT_W+1)'(i) >= vict_q) begin
            lh_d[i] = lh_q[i+1]; ll_d[i] = ll_q[i+1];
            le_d[i] = le_q[i+1]; li_d[i] = li_q[i+1];
          end
        n_d = n_q - SCNT_W'(1);
        ne_d = ne_q + 4'd1;
        if (cur_q > SCNT_W'(vict_q)) cur_d = cur_q - SCNT_W'(1);
        st_d = BK_INSERT;
      end
      BK_INSERT: begin
        for (int i = 1; i < SERVER_SLOTS; i++)
          if (SCNT_W'(i) > cur_q) begin
            lh_d[i] = lh_q[i-1]; ll_d[i] = ll_q[i-1];
            le_d[i] = le_q[i-1]; li_d[i] = li_q[i-1];
          end
        for (int i = 0; i < SERVER_SLOTS; i++)
          if (SCNT_W'(i) == cur_q) begin
            lh_d[i] = pend_high_i; ll_d[i] = pend_low_i;
            li_d[i] = (job_q.life == LIFE_INF);
            le_d[i] = (job_q.life == LIFE_INF) ? 64'd0 : now_q + lifems_q;
          end
        n_d = n_q + SCNT_W'(1);
        cur_d = cur_q + SCNT_W'(1);
        na_d = na_q + 4'd1;
        pi_d = pi_q + CNT_W'(1);
        st_d = BK_START;
      end
      BK_DONE: begin
        if (!ovalid_q || ready_i) begin
          ovalid_d = 1'b1;
          ost_d = ST_OK;
          oidx_d = 3'(NONE);
          oh_d = '0; ol_d = '0; oe_d = '0; oi_d = 1'b0;
          on_d = 3'(n_q);
          oa_d = na_q; ou_d = nu_q; od_d = nd_q; oev_d = ne_q;
          st_d = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SERVER_SLOTS; i++) begin
      lh_q[i] <= lh_d[i]; ll_q[i] <= ll_d[i]; le_q[i] <= le_d[i]; li_q[i] <= li_d[i];
    end
    job_q <= job_d;
    now_q <= now_d;
    lifems_q <= lifems_d;
    vict_q <= vict_d;
    ost_q <= ost_d; oidx_q <= oidx_d; oh_q <= oh_d; ol_q <= ol_d; oe_q <= oe_d;
    oi_q <= oi_d; on_q <= on_d; oa_q <= oa_d; ou_q <= ou_d; od_q <= od_d;
    oev_q <= oev_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      n_q <= '0;
      clast_q <= '0;
      chigh_q <= '0;
      pi_q <= '0;
      cur_q <= '0;
      na_q <= '0; nu_q <= '0; nd_q <= '0; ne_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      n_q <= n_d;
      clast_q <= clast_d;
      chigh_q <= chigh_d;
      pi_q <= pi_d;
      cur_q <= cur_d;
      na_q <= na_d; nu_q <= nu_d; nd_q <= nd_d; ne_q <= ne_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign valid_o = ovalid_q;
  assign status_o = ost_q;
  assign entry_index_o = oidx_q;
  assign entry_addr_high_o = oh_q;
  assign entry_addr_low_o = ol_q;
  assign expire_time_o = oe_q;
  assign never_expires_o = oi_q;
  assign server_count_o = on_q;
  assign added_count_o = oa_q;
  assign updated_count_o = ou_q;
  assign deleted_count_o = od_q;
  assign evicted_count_o = oev_q;

endmodule
`default_nettype wire

// ===== design/dnsl_checker.sv =====
// port checker for the dns server list table and its bind
`timescale 1ns / 1ps
`default_nettype none
module dnsl_checker
  import dnsl_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       valid_o,
  input wire logic       ready_i,
  input wire logic [1:0] status_o,
  input wire logic [2:0] entry_index_o,
  input wire logic [2:0] server_count_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(status_o))
    else $error("result dropped while stalled");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> server_count_o <= 3'(SERVER_SLOTS))
    else $error("server count out of range");

  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != ST_OK |-> entry_index_o == 3'(SERVER_SLOTS))
    else $error("entry reported on failure");

  a_within: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && entry_index_o != 3'(SERVER_SLOTS) |-> entry_index_o <= server_count_o)
    else $error("entry index beyond list");

endmodule

bind dns_server_list_table dnsl_checker u_checker (
  .clk_i, .rst_ni, .valid_o, .ready_i, .status_o, .entry_index_o, .server_count_o
);
`default_nettype wire

// ===== tb/tb_dns_server_list_table.sv =====
// testbench for the dns server list table: directed table, then randomized traffic
`timescale 1ns / 1ps
module tb_dns_server_list_table;
  import dnsl_pkg::*;

  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;
  localparam int unsigned NONE_IDX = SERVER_SLOTS;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    logic [2:0]  cmd;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] life;
    logic [31:0] ms;
    logic [7:0]  idx;
    logic        last;
  } dns_req_t;

  typedef struct {
    logic [1:0]  st;
    logic [2:0]  ent;
    logic [63:0] ah;
    logic [63:0] al;
    logic [63:0] expiry;
    logic        inf;
    logic [2:0]  cnt;
    logic [3:0]  added;
    logic [3:0]  updated;
    logic [3:0]  deleted;
    logic [3:0]  evicted;
  } dns_rsp_t;

  typedef struct {
    dns_req_t    req;
    logic        chk;
    status_e     st;
    logic [2:0]  cnt;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_o;
  logic [2:0] command_i = '0;
  logic [63:0] addr_high_i = '0;
  logic [63:0] addr_low_i = '0;
  logic [31:0] lifetime_s_i = '0;
  logic [31:0] now_ms_i = '0;
  logic [7:0] index_i = '0;
  logic last_of_option_i = 1'b0;
  logic valid_o;
  logic ready_i = 1'b0;
  logic [1:0] status_o;
  logic [2:0] entry_index_o;
  logic [63:0] entry_addr_high_o, entry_addr_low_o, expire_time_o;
  logic never_expires_o;
  logic [2:0] server_count_o;
  logic [3:0] added_count_o, updated_count_o, deleted_count_o, evicted_count_o;

  always #4 clk_i = ~clk_i;

  dns_server_list_table DUT (.*);

  // shadow copy of the table
  logic [63:0] sh_hi [SERVER_SLOTS];
  logic [63:0] sh_lo [SERVER_SLOTS];
  logic [63:0] sh_exp [SERVER_SLOTS];
  bit          sh_inf [SERVER_SLOTS];
  bit          sh_used [SERVER_SLOTS];
  logic [63:0] buf_hi [MAX_OPTION_ADDRESSES];
  logic [63:0] buf_lo [MAX_OPTION_ADDRESSES];
  int unsigned buf_cnt;
  bit          buf_over;
  logic [31:0] clk_last, clk_high;
  int unsigned n_add, n_upd, n_del, n_evi;

  dns_rsp_t expected_rsp_q[$];
  int errors, items_sent, rsp_checked, options_closed;
  int idle_pct, stall_pct;
  bit hold_req;

  function automatic logic [63:0] ext_time(logic [31:0] ms);
    if (ms < clk_last) clk_high = clk_high + 1;
    clk_last = ms;
    return {clk_high, ms};
  endfunction

  function automatic int unsigned used_slots();
    int unsigned n = 0;
    while (n < SERVER_SLOTS && sh_used[n]) n++;
    return n;
  endfunction

  function automatic int unsigned lookup(logic [63:0] hi, logic [63:0] lo);
    for (int unsigned i = 0; i < used_slots(); i++)
      if (sh_hi[i] == hi && sh_lo[i] == lo) return i;
    return NONE_IDX;
  endfunction

  function automatic void move_slot(int unsigned d, int unsigned s);
    sh_hi[d] = sh_hi[s]; sh_lo[d] = sh_lo[s]; sh_exp[d] = sh_exp[s];
    sh_inf[d] = sh_inf[s]; sh_used[d] = sh_used[s];
  endfunction

  function automatic void drop_slot(int unsigned at);
    int unsigned n = used_slots();
    if (at >= n) return;
    for (int unsigned i = at; i + 1 < n; i++) move_slot(i, i + 1);
    sh_hi[n-1] = '0; sh_lo[n-1] = '0; sh_exp[n-1] = '0;
    sh_inf[n-1] = 1'b0; sh_used[n-1] = 1'b0;
  endfunction

  // first finite entry with least time left; infinite ones lose unless all are
  function automatic int unsigned soonest(logic [63:0] t);
    int unsigned best = NONE_IDX;
    logic [63:0] least_left = '0;
    bit best_inf = 1'b1;
    logic [63:0] left;
    bit take;
    for (int unsigned i = 0; i < used_slots(); i++) begin
      left = (t > sh_exp[i]) ? 64'd0 : sh_exp[i] - t;
      if (best == NONE_IDX) take = 1'b1;
      else if (sh_inf[i]) take = 1'b0;
      else take = best_inf || left < least_left;
      if (take) begin
        best = i; least_left = left; best_inf = sh_inf[i];
      end
    end
    return best;
  endfunction

  function automatic void set_life(int unsigned i, logic [31:0] life, logic [63:0] t);
    sh_inf[i] = (life == LIFE_INF);
    sh_exp[i] = sh_inf[i] ? 64'd0 : t + {32'd0, life} * 64'd1000;
  endfunction

  function automatic void apply_addr(logic [63:0] hi, logic [63:0] lo, logic [31:0] life,
                                     logic [63:0] t, ref int unsigned cur);
    int unsigned at = lookup(hi, lo);
    int unsigned n, v;
    if (at != NONE_IDX) begin
      if (life == 0) begin
        drop_slot(at); n_del++;
        if (cur > at) cur--;
      end else begin
        set_life(at, life, t); n_upd++;
      end
      return;
    end
    if (life == 0) return;
    if (used_slots() == SERVER_SLOTS) begin
      v = soonest(t);
      drop_slot(v); n_evi++;
      if (cur > v) cur--;
    end
    n = used_slots();
    at = (cur > n) ? n : cur;
    for (int unsigned i = n; i > at; i--) move_slot(i, i - 1);
    sh_hi[at] = hi; sh_lo[at] = lo; set_life(at, life, t); sh_used[at] = 1'b1;
    cur++; n_add++;
  endfunction

  function automatic dns_rsp_t make_rsp(status_e st, int unsigned ent);
    dns_rsp_t r;
    r.st = st; r.ent = ent[2:0];
    r.ah = '0; r.al = '0; r.expiry = '0; r.inf = 1'b0;
    if (ent < SERVER_SLOTS) begin
      r.ah = sh_hi[ent]; r.al = sh_lo[ent]; r.expiry = sh_exp[ent]; r.inf = sh_inf[ent];
    end
    r.cnt = 3'(used_slots());
    r.added = 4'(n_add); r.updated = 4'(n_upd); r.deleted = 4'(n_del);
    r.evicted = 4'(n_evi);
    return r;
  endfunction

  // returns 1 when the request produces a response
  function automatic bit predict_table(dns_req_t q, output dns_rsp_t r);
    int unsigned at, cur, cnt;
    bit bad;
    logic [63:0] t;
    n_add = 0; n_upd = 0; n_del = 0; n_evi = 0;
    case (q.cmd)
      CMD_OPTION: begin
        if (buf_cnt < MAX_OPTION_ADDRESSES) begin
          buf_hi[buf_cnt] = q.hi; buf_lo[buf_cnt] = q.lo; buf_cnt++;
        end else buf_over = 1'b1;
        if (!q.last) return 1'b0;
        cnt = buf_cnt; bad = buf_over;
        for (int unsigned i = 0; i < cnt; i++)
          if (buf_hi[i][63:56] == MCAST_BYTE || (buf_hi[i] == 0 && buf_lo[i] == 0)) bad = 1'b1;
        buf_cnt = 0; buf_over = 1'b0;
        options_closed++;
        if (bad) begin
          r = make_rsp(ST_IGNORED, NONE_IDX);
          return 1'b1;
        end
        t = ext_time(q.ms); cur = 0;
        for (int unsigned i = 0; i < cnt; i++) apply_addr(buf_hi[i], buf_lo[i], q.life, t, cur);
        r = make_rsp(ST_OK, NONE_IDX);
      end
      CMD_GET: begin
        if (q.idx >= SERVER_SLOTS || !sh_used[q.idx]) r = make_rsp(ST_ERROR, NONE_IDX);
        else r = make_rsp(ST_OK, q.idx);
      end
      CMD_FIND: begin
        at = lookup(q.hi, q.lo);
        r = make_rsp(at != NONE_IDX ? ST_OK : ST_ERROR, at);
      end
      CMD_REMOVE: begin
        at = lookup(q.hi, q.lo);
        if (at == NONE_IDX) r = make_rsp(ST_ERROR, NONE_IDX);
        else begin
          r = make_rsp(ST_OK, at);
          drop_slot(at);
          r.cnt = 3'(used_slots()); r.deleted = 4'd1;
        end
      end
      CMD_TICK: begin
        t = ext_time(q.ms);
        for (int unsigned i = 0; i < used_slots(); i++)
          if (!sh_inf[i] && t > sh_exp[i]) begin
            r = make_rsp(ST_OK, i);
            drop_slot(i);
            r.cnt = 3'(used_slots());
            return 1'b1;
          end
        r = make_rsp(ST_NONE, NONE_IDX);
      end
      default: r = make_rsp(ST_ERROR, NONE_IDX);
    endcase
    return 1'b1;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  // response side
  always @(posedge clk_i) begin
    dns_rsp_t w;
    if (rst_ni && valid_o && ready_i) begin
      if (expected_rsp_q.size() == 0) report("unexpected response, status", status_o, '0);
      else begin
        w = expected_rsp_q.pop_front();
        rsp_checked++;
        if (status_o != w.st) report("status", status_o, w.st);
        if (entry_index_o != w.ent) report("entry_index", entry_index_o, w.ent);
        if (entry_addr_high_o != w.ah) report("entry_addr_high", entry_addr_high_o, w.ah);
        if (entry_addr_low_o != w.al) report("entry_addr_low", entry_addr_low_o, w.al);
        if (expire_time_o != w.expiry) report("expire_time", expire_time_o, w.expiry);
        if (never_expires_o != w.inf) report("never_expires", never_expires_o, w.inf);
        if (server_count_o != w.cnt) report("server_count", server_count_o, w.cnt);
        if (added_count_o != w.added) report("added_count", added_count_o, w.added);
        if (updated_count_o != w.updated) report("updated_count", updated_count_o, w.updated);
        if (deleted_count_o != w.deleted) report("deleted_count", deleted_count_o, w.deleted);
        if (evicted_count_o != w.evicted) report("evicted_count", evicted_count_o, w.evicted);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off counted here
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_req(dns_req_t q, output bit got, output dns_rsp_t r);
    while ($urandom_range(99) < idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    command_i <= q.cmd; addr_high_i <= q.hi; addr_low_i <= q.lo;
    lifetime_s_i <= q.life; now_ms_i <= q.ms; index_i <= q.idx;
    last_of_option_i <= q.last;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    items_sent++;
    got = predict_table(q, r);
    if (got) expected_rsp_q.push_back(r);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // address pool so that random traffic hits known entries
  logic [63:0] pool_hi [8];
  logic [63:0] pool_lo [8];
  logic [31:0] tb_ms;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void refresh_pool(int k);
    pool_hi[k] = rand64(); pool_lo[k] = rand64();
    if (pool_hi[k][63:56] == MCAST_BYTE) pool_hi[k][63:56] = 8'hFE;
  endfunction

  function automatic logic [31:0] rand_life();
    int unsigned r = $urandom_range(99);
    if (r < 15) return 32'd0;
    if (r < 30) return LIFE_INF;
    if (r < 80) return $urandom_range(1, 12);
    return $urandom;
  endfunction

  function automatic logic [31:0] step_ms();
    if ($urandom_range(99) < 4) tb_ms = tb_ms + $urandom;
    else tb_ms = tb_ms + $urandom_range(0, 30000);
    return tb_ms;
  endfunction

  task automatic send_other();
    dns_req_t q;
    bit got;
    dns_rsp_t r;
    int unsigned k = $urandom_range(7);
    int unsigned c = $urandom_range(99);
    q.hi = pool_hi[k]; q.lo = pool_lo[k];
    if ($urandom_range(9) == 0) begin
      q.hi = rand64(); q.lo = rand64();
    end
    q.life = $urandom; q.ms = $urandom; q.last = 1'($urandom_range(1));
    q.idx = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(5));
    if (c < 25) q.cmd = CMD_GET;
    else if (c < 50) q.cmd = CMD_FIND;
    else if (c < 70) q.cmd = CMD_REMOVE;
    else if (c < 96) begin
      q.cmd = CMD_TICK; q.ms = step_ms();
    end else q.cmd = $urandom_range(1) ? CMD_RSVD_LO : CMD_RSVD_HI;
    send_req(q, got, r);
  endtask

  task automatic send_option();
    dns_req_t q;
    bit got;
    dns_rsp_t r;
    int unsigned len = ($urandom_range(99) < 5) ? $urandom_range(9, 11) : $urandom_range(1, 3);
    int bad_at = ($urandom_range(99) < 6) ? int'($urandom_range(len - 1)) : -1;
    logic [31:0] life = rand_life();
    if ($urandom_range(19) == 0) refresh_pool($urandom_range(7));
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(9) == 0) send_other();
      q.cmd = CMD_OPTION;
      q.hi = pool_hi[$urandom_range(7)];
      q.lo = pool_lo[$urandom_range(7)];
      q.lo = pool_lo[$urandom_range(7)] ^ ((q.hi == 0) ? 64'd1 : 64'd0);
      if (k == bad_at) begin
        if ($urandom_range(1)) begin
          q.hi = {MCAST_BYTE, 56'(rand64())}; q.lo = rand64();
        end else begin
          q.hi = '0; q.lo = '0;
        end
      end
      q.idx = 8'($urandom);
      q.last = (k == len - 1);
      q.life = q.last ? life : $urandom;
      q.ms = q.last ? step_ms() : $urandom;
      send_req(q, got, r);
    end
  endtask

  task automatic run_random(int n);
    int stop = items_sent + n;
    while (items_sent < stop) begin
      if ($urandom_range(99) < 55) send_option();
      else send_other();
    end
  endtask

  localparam logic [63:0] A_HI = 64'h2001_0db8_0000_0001;
  localparam logic [63:0] D_HI = 64'hFEFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  dir_row_t dir_tab [] = '{
    '{'{CMD_GET,    0, 0, 0, 0, 0, 0},                  1, ST_ERROR, 3'd0},
    '{'{CMD_TICK,   0, 0, 0, 5, 0, 0},                  1, ST_NONE, 3'd0},
    '{'{CMD_FIND,   A_HI, 1, 0, 0, 0, 0},               1, ST_ERROR, 3'd0},
    '{'{CMD_REMOVE, A_HI, 1, 0, 0, 0, 0},               1, ST_ERROR, 3'd0},
    '{'{CMD_RSVD_LO, A_HI, 1, 0, 0, 0, 0},              1, ST_ERROR, 3'd0},
    '{'{CMD_RSVD_HI, ONES, ONES, ONES, ONES, 8'hFF, 1}, 1, ST_ERROR, 3'd0},
    '{'{CMD_OPTION, 64'hFF02_0000_0000_0000, 1, 10, 100, 0, 1}, 1, ST_IGNORED, 3'd0},
    '{'{CMD_OPTION, 0, 0, 10, 100, 0, 1},               1, ST_IGNORED, 3'd0},
    '{'{CMD_OPTION, A_HI, 1, 0, 0, 0, 0},               0, ST_OK, 3'd0},
    '{'{CMD_OPTION, A_HI, 2, 0, 0, 0, 0},               0, ST_OK, 3'd0},
    '{'{CMD_OPTION, A_HI, 3, 10, 1000, 0, 1},           1, ST_OK, 3'd3},
    '{'{CMD_OPTION, D_HI, ONES, 0, 0, 0, 0},            0, ST_OK, 3'd0},
    '{'{CMD_OPTION, 0, 1, LIFE_INF, 2000, 0, 1},        1, ST_OK, 3'd4},
    '{'{CMD_GET,    0, 0, 0, 0, 8'hFF, 0},              1, ST_ERROR, 3'd4},
    '{'{CMD_GET,    0, 0, 0, 0, 3, 0},                  0, ST_OK, 3'd0},
    '{'{CMD_FIND,   A_HI, 3, 0, 0, 0, 0},               0, ST_OK, 3'd0},
    '{'{CMD_OPTION, A_HI, 3, 0, 3000, 0, 1},            0, ST_OK, 3'd0},
    '{'{CMD_OPTION, A_HI, 9, 0, 3100, 0, 1},            0, ST_OK, 3'd0},
    '{'{CMD_OPTION, A_HI, 2, 32'hFFFF_FFFE, 32'hFFFF_FFF0, 0, 1}, 0, ST_OK, 3'd0},
    '{'{CMD_TICK,   0, 0, 0, 10, 0, 0},                 0, ST_OK, 3'd0},
    '{'{CMD_TICK,   0, 0, 0, 20, 0, 0},                 0, ST_OK, 3'd0},
    '{'{CMD_REMOVE, D_HI, ONES, 0, 0, 0, 0},            0, ST_OK, 3'd0}
  };

  initial begin
    dns_req_t q;
    bit got;
    dns_rsp_t r;
    for (int i = 0; i < SERVER_SLOTS; i++) begin
      sh_hi[i] = '0; sh_lo[i] = '0; sh_exp[i] = '0; sh_inf[i] = 0; sh_used[i] = 0;
    end
    buf_cnt = 0; buf_over = 0; clk_last = '0; clk_high = '0;
    errors = 0; items_sent = 0; rsp_checked = 0; options_closed = 0;
    idle_pct = 0; stall_pct = 0; hold_req = 0; tb_ms = '0;
    for (int k = 0; k < 8; k++) refresh_pool(k);
    pool_hi[0] = A_HI; pool_lo[0] = 64'd1;
    pool_hi[1] = D_HI; pool_lo[1] = ONES;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].req, got, r);
      if (dir_tab[i].chk && (!got || r.st != dir_tab[i].st || r.cnt != dir_tab[i].cnt))
        report($sformatf("table row %0d status/count", i), {r.st, r.cnt},
               {dir_tab[i].st, dir_tab[i].cnt});
    end
    // option that overflows the address buffer
    for (int k = 0; k < 9; k++) begin
      q = '{CMD_OPTION, A_HI, 64'(k + 20), 30, 5000, 0, k == 8};
      send_req(q, got, r);
    end

    idle_pct = 0;  stall_pct = 0;  run_random(100);
    idle_pct = 62; stall_pct = 0;  run_random(120);
    idle_pct = 0;  stall_pct = 62; run_random(120);
    idle_pct = 6;  stall_pct = 6;  run_random(120);
    // long receiver hold-off while the sender keeps offering
    idle_pct = 0;  stall_pct = 0;  hold_req = 1'b1; run_random(60);
    drain();
    repeat ($urandom_range(5, 40)) @(posedge clk_i);
    stall_pct = 30; idle_pct = 30; run_random(100);

    drain();
    repeat (60) @(posedge clk_i);
    $display("covered %0d transfers in, %0d responses checked, %0d options closed",
             items_sent, rsp_checked, options_closed);
    $display("incl. bad and overflowing options, evictions, clock wraps, stalls and hold-off");
    if (errors == 0 && expected_rsp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d responses missing", errors, expected_rsp_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
